@@ src/swarq_pkg.sv @@
// Package: shared types, codes and reset constants of the stop-and-wait ARQ controller.
`timescale 1ns / 1ps

package swarq_pkg;

	// Default sequence width and fixed field widths
	localparam int SEQ_BITS_DEF = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	// Configuration reset values and the resend counter saturation value
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [3:0]  MAXRES_RST  = 4'd5;
	localparam logic [3:0]  RESEND_SAT  = 4'd15;

	// Received command bytes
	localparam logic [7:0] CMD_DATA = 8'h05;
	localparam logic [7:0] CMD_ACK  = 8'h06;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT = 1'b0,
		CFG_MAXRES  = 1'b1
	} cfg_idx_t;

	// Input event codes
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_RX   = 2'd1,
		OP_SEND = 2'd2
	} op_t;

	// Header kinds to send
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_DATA = 2'd1,
		KIND_ACK  = 2'd2
	} kind_t;

	// User reports
	typedef enum logic [2:0] {
		REP_NONE     = 3'd0,
		REP_RECEIVED = 3'd1,
		REP_SUCCESS  = 3'd2,
		REP_BAD_ACK  = 3'd3,
		REP_NO_ACK   = 3'd4,
		REP_BUSY     = 3'd5
	} rep_t;

	// Input item
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_seq;
		logic [7:0] rx_cmd;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [1:0] tx_kind;
		logic [7:0] tx_seq;
		logic [2:0] report;
	} out_item_t;

	// Live configuration
	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [3:0]  resend_limit;
	} cfg_t;

endpackage

@@ src/swarq_cfg.sv @@
// Configuration register file: timeout and resend limit.
`timescale 1ns / 1ps

module swarq_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swarq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swarq_pkg::CFG_DATA_W-1:0]    cfg_data,
	output swarq_pkg::cfg_t                     cfg
);

	swarq_pkg::cfg_t cfg_q;

	// Take every write at once
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Hold registers, update on a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= swarq_pkg::TIMEOUT_RST;
			cfg_q.resend_limit  <= swarq_pkg::MAXRES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				swarq_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				swarq_pkg::CFG_MAXRES:  cfg_q.resend_limit  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/swarq_ctrl.sv @@
// Link state and per-event decision logic of the ARQ controller.
`timescale 1ns / 1ps

module swarq_ctrl #(
	parameter int SEQ_BITS = swarq_pkg::SEQ_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  swarq_pkg::in_item_t  item,
	input  swarq_pkg::cfg_t      cfg,
	output logic                 res_valid,
	output swarq_pkg::out_item_t res
);

	logic                awaiting_q, awaiting_n;
	logic [SEQ_BITS-1:0] send_seq_q, send_seq_n;
	logic [SEQ_BITS-1:0] recv_seq_q, recv_seq_n;
	logic [3:0]          resend_q, resend_n;
	logic [16:0]         tick_q, tick_n;

	logic [16:0]         tick_inc;
	logic [SEQ_BITS-1:0] seq_in;
	logic [SEQ_BITS-1:0] send_inc;

	assign tick_inc = tick_q + 17'd1;
	assign seq_in   = SEQ_BITS'(item.rx_seq);
	assign send_inc = send_seq_q + SEQ_BITS'(1);

	// Decide result and next state for the staged event
	always_comb begin
		awaiting_n = awaiting_q;
		send_seq_n = send_seq_q;
		recv_seq_n = recv_seq_q;
		resend_n   = resend_q;
		tick_n     = tick_q;
		res_valid  = 1'b0;
		res        = '0;
		unique case (item.opcode)
			swarq_pkg::OP_TICK: begin
				if (awaiting_q) begin
					tick_n = tick_inc;
					if (tick_inc > {1'b0, cfg.timeout_ticks}) begin
						tick_n    = '0;
						res_valid = 1'b1;
						if (resend_q > cfg.resend_limit) begin
							awaiting_n = 1'b0;
							res.report = swarq_pkg::REP_NO_ACK;
						end else begin
							if (resend_q != swarq_pkg::RESEND_SAT) begin
								resend_n = resend_q + 4'd1;
							end
							res.tx_kind = swarq_pkg::KIND_DATA;
							res.tx_seq  = 8'(send_seq_q);
						end
					end
				end
			end
			swarq_pkg::OP_RX: begin
				if (!awaiting_q) begin
					// Acknowledge data, deliver only a new sequence
					if (item.rx_cmd == swarq_pkg::CMD_DATA) begin
						res_valid   = 1'b1;
						res.tx_kind = swarq_pkg::KIND_ACK;
						res.tx_seq  = 8'(seq_in);
						if (recv_seq_q != seq_in) begin
							recv_seq_n = seq_in;
							res.report = swarq_pkg::REP_RECEIVED;
						end
					end
				end else begin
					awaiting_n = 1'b0;
					res_valid  = 1'b1;
					if (item.rx_cmd == swarq_pkg::CMD_ACK && seq_in == send_seq_q) begin
						res.report = swarq_pkg::REP_SUCCESS;
					end else begin
						res.report = swarq_pkg::REP_BAD_ACK;
					end
				end
			end
			swarq_pkg::OP_SEND: begin
				res_valid = 1'b1;
				if (awaiting_q) begin
					res.report = swarq_pkg::REP_BUSY;
				end else begin
					send_seq_n  = send_inc;
					resend_n    = '0;
					tick_n      = '0;
					awaiting_n  = 1'b1;
					res.tx_kind = swarq_pkg::KIND_DATA;
					res.tx_seq  = 8'(send_inc);
				end
			end
			default: ;
		endcase
	end

	// Advance state when the event leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			send_seq_q <= '0;
			recv_seq_q <= '0;
			resend_q   <= '0;
			tick_q     <= '0;
		end else if (fire) begin
			awaiting_q <= awaiting_n;
			send_seq_q <= send_seq_n;
			recv_seq_q <= recv_seq_n;
			resend_q   <= resend_n;
			tick_q     <= tick_n;
		end
	end

endmodule

@@ src/stop_and_wait_arq_controller_core.sv @@
// Top level of the stop-and-wait ARQ controller: input stage, decision, result register.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one event per transfer - timer tick,
//     received packet header (rx_seq, rx_cmd) or send request.
//   out channel (out_valid/out_ready/out_data): at most one result per event,
//     carrying the header to send (tx_kind, tx_seq) and a user report.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 timeout in
//     ticks, index 1 resend limit; always ready, write only while idle.
// Path: an accepted event waits in the input stage; its result, if it has one,
//   is loaded into the output register as the event leaves that stage.
// Throughput: one event per cycle while results are taken; the input stage and
//   output register form a two-deep pipeline, and the link state updates as
//   each event leaves stage one.
// Reset: arst_n clears the link state and both stages; configuration returns to
//   timeout 1000 and resend limit 5.
// Receiver stall: the result waits in the output register; the staged event
//   holds, and in_ready drops once both stages are full.
`timescale 1ns / 1ps

module stop_and_wait_arq_controller_core #(
	parameter int SEQ_BITS = swarq_pkg::SEQ_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  swarq_pkg::in_item_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output swarq_pkg::out_item_t                out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swarq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swarq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	swarq_pkg::cfg_t      cfg;
	swarq_pkg::in_item_t  item_s1;
	logic                 valid_s1;
	swarq_pkg::out_item_t res;
	logic                 res_valid;
	swarq_pkg::out_item_t out_q;
	logic                 out_valid_q;
	logic                 fire;

	swarq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swarq_ctrl #(
		.SEQ_BITS (SEQ_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Move the staged event on when the output register has room
	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Result register: load on a result, drop after the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

endmodule

@@ src/swarq_chk.sv @@
// Port-level checker for the ARQ controller and its bind to the top level.
`timescale 1ns / 1ps

module swarq_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input swarq_pkg::out_item_t                out_data
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// No header means a zero sequence byte
	a_none_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_kind == swarq_pkg::KIND_NONE |-> out_data.tx_seq == 8'd0)
		else $error("sequence byte set without a header");

	// A data header carries no report
	a_data_rep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_kind == swarq_pkg::KIND_DATA
		|-> out_data.report == swarq_pkg::REP_NONE)
		else $error("data header with a report");

	// An ack header reports at most a delivery
	a_ack_rep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_kind == swarq_pkg::KIND_ACK
		|-> out_data.report == swarq_pkg::REP_NONE
			|| out_data.report == swarq_pkg::REP_RECEIVED)
		else $error("ack header with a send outcome");

	// Send outcomes never ask for a header
	a_outcome_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.report == swarq_pkg::REP_SUCCESS
			|| out_data.report == swarq_pkg::REP_BAD_ACK
			|| out_data.report == swarq_pkg::REP_NO_ACK
			|| out_data.report == swarq_pkg::REP_BUSY)
		|-> out_data.tx_kind == swarq_pkg::KIND_NONE)
		else $error("send outcome with a header");

endmodule

bind stop_and_wait_arq_controller_core swarq_chk u_swarq_chk (.*);

@@ test/tb.sv @@
// Testbench for the stop-and-wait ARQ controller: directed and random events.
`timescale 1ns / 1ps

module tb;

	localparam int         CYCLE_LIMIT    = 1_000_000;
	localparam int         SETTLE_CYCLES  = 6;
	localparam int         RX_HOLD_CYCLES = 300;
	localparam int         MAX_PRINTS     = 100;
	localparam int         RANDOM_PHASES  = 4;
	localparam int         PHASE_ITEMS    = 60;
	localparam int         SEND_ROUNDS    = 20;
	localparam int         LONG_TICKS     = 20;
	localparam logic [1:0] OP_UNUSED      = 2'd3;

	logic                                  clk       = 1'b0;
	logic                                  arst_n    = 1'b0;
	logic                                  in_valid  = 1'b0;
	logic                                  in_ready;
	swarq_pkg::in_item_t                   in_data   = '0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	swarq_pkg::out_item_t                  out_data;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [swarq_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [swarq_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

	// Predicted link state and live configuration
	logic [15:0] lk_timeout;
	logic [3:0]  lk_resend_limit;
	logic        lk_awaiting;
	logic [7:0]  lk_send_seq;
	logic [7:0]  lk_recv_seq;
	logic [3:0]  lk_resends;
	logic [16:0] lk_ticks;

	swarq_pkg::out_item_t replies_due[$];
	int                   errors       = 0;
	int                   cycles       = 0;
	int                   in_idle_pct  = 37;
	int                   out_idle_pct = 37;
	int                   stall_req    = 0;
	int                   stall_ack    = 0;
	int                   hold_left    = 0;

	stop_and_wait_arq_controller_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Drive result ready: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (stall_ack != stall_req) begin
			stall_ack = stall_req;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= out_idle_pct);
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (errors < MAX_PRINTS)
			$display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	// Compare each result transfer with the oldest predicted reply
	always @(posedge clk) begin : result_check
		swarq_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				flag_mismatch("unexpected result, report", int'(out_data.report), -1);
			end else begin
				want = replies_due.pop_front();
				if (out_data.tx_kind !== want.tx_kind)
					flag_mismatch("tx_kind", int'(out_data.tx_kind), int'(want.tx_kind));
				if (out_data.tx_seq !== want.tx_seq)
					flag_mismatch("tx_seq", int'(out_data.tx_seq), int'(want.tx_seq));
				if (out_data.report !== want.report)
					flag_mismatch("report", int'(out_data.report), int'(want.report));
			end
		end
	end

	function automatic void expect_reply(input swarq_pkg::kind_t kind,
			input logic [7:0] seq, input swarq_pkg::rep_t rep);
		swarq_pkg::out_item_t r;
		r.tx_kind = kind;
		r.tx_seq  = seq;
		r.report  = rep;
		replies_due.push_back(r);
	endfunction

	function automatic void reset_link_model();
		lk_timeout      = swarq_pkg::TIMEOUT_RST;
		lk_resend_limit = swarq_pkg::MAXRES_RST;
		lk_awaiting     = 1'b0;
		lk_send_seq     = '0;
		lk_recv_seq     = '0;
		lk_resends      = '0;
		lk_ticks        = '0;
	endfunction

	// Advance the link state by one event and queue the reply it causes
	function automatic void predict_event(input swarq_pkg::in_item_t ev);
		swarq_pkg::rep_t rep;
		case (ev.opcode)
			swarq_pkg::OP_TICK: begin
				if (lk_awaiting) begin
					lk_ticks = lk_ticks + 17'd1;
					if (lk_ticks > {1'b0, lk_timeout}) begin
						lk_ticks = '0;
						if (lk_resends > lk_resend_limit) begin
							lk_awaiting = 1'b0;
							expect_reply(swarq_pkg::KIND_NONE, 8'd0, swarq_pkg::REP_NO_ACK);
						end else begin
							if (lk_resends != swarq_pkg::RESEND_SAT)
								lk_resends = lk_resends + 4'd1;
							expect_reply(swarq_pkg::KIND_DATA, lk_send_seq,
								swarq_pkg::REP_NONE);
						end
					end
				end
			end
			swarq_pkg::OP_RX: begin
				if (!lk_awaiting) begin
					if (ev.rx_cmd == swarq_pkg::CMD_DATA) begin
						rep = swarq_pkg::REP_NONE;
						if (lk_recv_seq != ev.rx_seq) begin
							lk_recv_seq = ev.rx_seq;
							rep = swarq_pkg::REP_RECEIVED;
						end
						expect_reply(swarq_pkg::KIND_ACK, ev.rx_seq, rep);
					end
				end else begin
					lk_awaiting = 1'b0;
					if (ev.rx_cmd == swarq_pkg::CMD_ACK && ev.rx_seq == lk_send_seq)
						expect_reply(swarq_pkg::KIND_NONE, 8'd0, swarq_pkg::REP_SUCCESS);
					else
						expect_reply(swarq_pkg::KIND_NONE, 8'd0, swarq_pkg::REP_BAD_ACK);
				end
			end
			swarq_pkg::OP_SEND: begin
				if (lk_awaiting) begin
					expect_reply(swarq_pkg::KIND_NONE, 8'd0, swarq_pkg::REP_BUSY);
				end else begin
					lk_send_seq = lk_send_seq + 8'd1;
					lk_resends  = '0;
					lk_ticks    = '0;
					lk_awaiting = 1'b1;
					expect_reply(swarq_pkg::KIND_DATA, lk_send_seq, swarq_pkg::REP_NONE);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic swarq_pkg::in_item_t ev_of(input logic [1:0] op,
			input logic [7:0] seq, input logic [7:0] cmd);
		swarq_pkg::in_item_t ev;
		ev.opcode = op;
		ev.rx_seq = seq;
		ev.rx_cmd = cmd;
		return ev;
	endfunction

	// Offer one event, hold it until the transfer, then predict its reply
	task automatic send_event(input swarq_pkg::in_item_t ev);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = ev;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_event(ev);
	endtask

	// Drop valid, wait for every reply, then cover events that give none
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input swarq_pkg::cfg_idx_t idx, input logic [15:0] val);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == swarq_pkg::CFG_TIMEOUT)
			lk_timeout = val;
		else
			lk_resend_limit = val[3:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly well-formed exchanges shaped by the current link state, some noise
	function automatic swarq_pkg::in_item_t pick_event();
		swarq_pkg::in_item_t ev;
		int roll;
		ev.opcode = swarq_pkg::OP_TICK;
		ev.rx_seq = 8'($urandom);
		ev.rx_cmd = 8'($urandom);
		roll = $urandom_range(99);
		if (roll < 6) begin
			ev.opcode = OP_UNUSED;
		end else if (lk_awaiting) begin
			if (roll < 60) begin
				ev.opcode = swarq_pkg::OP_TICK;
			end else if (roll < 88) begin
				ev.opcode = swarq_pkg::OP_RX;
				roll = $urandom_range(99);
				if (roll < 70) begin
					ev.rx_cmd = swarq_pkg::CMD_ACK;
					ev.rx_seq = lk_send_seq;
				end else if (roll < 85) begin
					ev.rx_cmd = swarq_pkg::CMD_ACK;
				end else if (roll < 93) begin
					ev.rx_cmd = swarq_pkg::CMD_DATA;
				end
			end else begin
				ev.opcode = swarq_pkg::OP_SEND;
			end
		end else begin
			if (roll < 20) begin
				ev.opcode = swarq_pkg::OP_TICK;
			end else if (roll < 60) begin
				ev.opcode = swarq_pkg::OP_RX;
				roll = $urandom_range(99);
				if (roll < 50) begin
					ev.rx_cmd = swarq_pkg::CMD_DATA;
					ev.rx_seq = lk_recv_seq + 8'd1;
				end else if (roll < 70) begin
					ev.rx_cmd = swarq_pkg::CMD_DATA;
					ev.rx_seq = lk_recv_seq;
				end else if (roll < 85) begin
					ev.rx_cmd = swarq_pkg::CMD_DATA;
				end
			end else begin
				ev.opcode = swarq_pkg::OP_SEND;
			end
		end
		return ev;
	endfunction

	// Events ignored while idle, and received data with duplicates
	task automatic test_idle_events();
		send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
		send_event(ev_of(OP_UNUSED, 8'hFF, 8'hFF));
		send_event(ev_of(swarq_pkg::OP_RX, 8'hFF, 8'hFF));
		send_event(ev_of(swarq_pkg::OP_RX, 8'h00, swarq_pkg::CMD_ACK));
		send_event(ev_of(swarq_pkg::OP_RX, 8'h00, swarq_pkg::CMD_DATA));
		send_event(ev_of(swarq_pkg::OP_RX, 8'hFF, swarq_pkg::CMD_DATA));
		send_event(ev_of(swarq_pkg::OP_RX, 8'hFF, swarq_pkg::CMD_DATA));
		send_event(ev_of(swarq_pkg::OP_RX, 8'h00, swarq_pkg::CMD_DATA));
	endtask

	// Send, busy, good ack and the kinds of bad ack
	task automatic test_link_handshakes();
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_SEND, 8'hFF, 8'hFF));
		send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, swarq_pkg::CMD_ACK));
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, swarq_pkg::CMD_DATA));
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_RX, 8'hFF, swarq_pkg::CMD_ACK));
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, 8'h00));
	endtask

	// Zero timeout with resend limits at both ends, including saturation
	task automatic test_timeout_limits();
		logic [15:0] val;
		write_reg(swarq_pkg::CFG_TIMEOUT, 16'd0);
		write_reg(swarq_pkg::CFG_MAXRES, 16'd0);
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		repeat (3) send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
		// upper data bits set: only the low nibble counts
		write_reg(swarq_pkg::CFG_MAXRES, 16'hFFFF);
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		repeat (20) send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, swarq_pkg::CMD_ACK));
		val = 16'($urandom);
		val[3:0] = 4'd14;
		write_reg(swarq_pkg::CFG_MAXRES, val);
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		repeat (17) send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
		write_reg(swarq_pkg::CFG_TIMEOUT, 16'd2);
		write_reg(swarq_pkg::CFG_MAXRES, 16'd1);
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		repeat (10) send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
	endtask

	// Largest timeout: a run of ticks gives no resend
	task automatic test_long_timeout();
		write_reg(swarq_pkg::CFG_TIMEOUT, 16'hFFFF);
		write_reg(swarq_pkg::CFG_MAXRES, 16'd0);
		send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
		repeat (LONG_TICKS) send_event(ev_of(swarq_pkg::OP_TICK, 8'h00, 8'h00));
		send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, swarq_pkg::CMD_ACK));
	endtask

	// Send and ack rounds that advance the send sequence
	task automatic test_send_rounds();
		repeat (SEND_ROUNDS) begin
			send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
			send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, swarq_pkg::CMD_ACK));
		end
	endtask

	// Hold off the receiver while events keep coming, so the input stalls
	task automatic test_backpressure();
		settle();
		in_idle_pct = 0;
		stall_req++;
		repeat (10) begin
			send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
			send_event(ev_of(swarq_pkg::OP_SEND, 8'h00, 8'h00));
			send_event(ev_of(swarq_pkg::OP_RX, lk_send_seq, swarq_pkg::CMD_ACK));
		end
		in_idle_pct = 37;
	endtask

	// Random traffic over several settings, one phase without idling
	task automatic test_random_traffic();
		logic [15:0] val;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(swarq_pkg::CFG_TIMEOUT, 16'($urandom_range(3)));
					write_reg(swarq_pkg::CFG_MAXRES, 16'($urandom_range(2)));
				end
				1: begin
					write_reg(swarq_pkg::CFG_TIMEOUT, 16'd0);
					write_reg(swarq_pkg::CFG_MAXRES, 16'd15);
				end
				2: begin
					write_reg(swarq_pkg::CFG_TIMEOUT, 16'($urandom_range(10)));
					write_reg(swarq_pkg::CFG_MAXRES, 16'd14);
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
				default: begin
					val = 16'($urandom);
					val[3:0] = 4'($urandom_range(15));
					write_reg(swarq_pkg::CFG_TIMEOUT, 16'($urandom_range(6)));
					write_reg(swarq_pkg::CFG_MAXRES, val);
				end
			endcase
			repeat (PHASE_ITEMS)
				send_event(pick_event());
			in_idle_pct  = 37;
			out_idle_pct = 37;
		end
	endtask

	initial begin
		reset_link_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_events();
		test_link_handshakes();
		test_timeout_limits();
		test_long_timeout();
		test_send_rounds();
		test_backpressure();
		test_random_traffic();
		settle();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
